@@ rtl/twq_pkg.sv @@
package twq_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 8;
  localparam int WAIT_W  = 16;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = PTR_W + 2;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [WAIT_W-1:0]  ticks_t;

  typedef struct packed {
    id_t    tid;
    ticks_t ticks;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    REQ_BLOCK   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_TICK    = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STAT_BLOCKED  = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_RELEASED = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_TIMEOUT  = 3'd4,
    STAT_NONE     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_TICK,
    ST_FLUSH
  } state_e;

  // ring address: head plus offset, wrapped at DEPTH
  function automatic ptr_t ptr_add(input ptr_t head, input cnt_t idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(idx);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

@@ rtl/twq_if.sv @@
interface twq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  thread_id;
  logic [15:0] wait_ticks;

  modport source (output valid, req_type, thread_id, wait_ticks, input ready);
  modport sink   (input valid, req_type, thread_id, wait_ticks, output ready);
endinterface

interface twq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] released_id;
  logic [4:0] blocked_count;
  logic       last_of_run;

  modport source (output valid, status, released_id, blocked_count, last_of_run,
                  input ready);
  modport sink   (input valid, status, released_id, blocked_count, last_of_run,
                  output ready);
endinterface

@@ rtl/twq_ram.sv @@
module twq_ram #(
  parameter int DATA_W  = 24,
  parameter int DEPTH_P = 16,
  parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH_P];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/timed_wait_queue.sv @@
// Block and release-empty: the flush state loads the result beat into the output
// register once free. Release oldest first reads the head entry. Tick: the walk
// reads one entry per cycle, held while an expiry waits on a busy output, from
// the single-read-port entry memory and writes survivors back in order.
// One request in flight; a new one is taken while the last result beat waits.
// Reset clears the queue pointers and control; entry memory is left as is.
module timed_wait_queue (
  input  logic clk_i,
  input  logic rst_ni,
  twq_in_if.sink    in_i,
  twq_out_if.source out_o
);
  import twq_pkg::*;

  state_e  state_q, state_d;
  ptr_t    head_q, head_d;
  cnt_t    count_q, count_d;
  cnt_t    src_q, src_d;
  cnt_t    dst_q, dst_d;
  cnt_t    total_q, total_d;
  logic    pv_q, pv_d;
  logic    held_v_q, held_v_d;
  status_e held_st_q, held_st_d;
  id_t     held_id_q, held_id_d;
  cnt_t    held_cnt_q, held_cnt_d;

  logic    ov_q, ov_d;
  status_e ost_q, ost_d;
  id_t     oid_q, oid_d;
  cnt_t    ocnt_q, ocnt_d;
  logic    olast_q, olast_d;

  logic    we, re;
  ptr_t    waddr, raddr;
  entry_t  wdata, rdata;

  logic    out_free, expire, stall;
  logic    push, push_last;
  status_e push_st;
  id_t     push_id;
  cnt_t    push_cnt;

  twq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH_P(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free = !ov_q || out_o.ready;
  assign expire   = pv_q && (rdata.ticks == WAIT_W'(1));
  assign stall    = expire && held_v_q && !out_free;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    src_d      = src_q;
    dst_d      = dst_q;
    total_d    = total_q;
    pv_d       = pv_q;
    held_v_d   = held_v_q;
    held_st_d  = held_st_q;
    held_id_d  = held_id_q;
    held_cnt_d = held_cnt_q;
    we         = 1'b0;
    waddr      = ptr_add(head_q, count_q);
    wdata      = '0;
    re         = 1'b0;
    raddr      = head_q;
    push       = 1'b0;
    push_last  = 1'b0;
    push_st    = held_st_q;
    push_id    = held_id_q;
    push_cnt   = held_cnt_q;
    in_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.req_type)
            REQ_BLOCK: begin
              held_v_d  = 1'b1;
              held_id_d = '0;
              state_d   = ST_FLUSH;
              if (count_q == CNT_W'(DEPTH)) begin
                held_st_d  = STAT_FULL;
                held_cnt_d = count_q;
              end else begin
                we          = 1'b1;
                wdata.tid   = ID_BITS'(in_i.thread_id);
                wdata.ticks = in_i.wait_ticks;
                count_d     = count_q + CNT_W'(1);
                held_st_d   = STAT_BLOCKED;
                held_cnt_d  = count_q + CNT_W'(1);
              end
            end
            REQ_RELEASE: begin
              held_v_d = 1'b1;
              if (count_q == '0) begin
                held_st_d  = STAT_EMPTY;
                held_id_d  = '0;
                held_cnt_d = '0;
                state_d    = ST_FLUSH;
              end else begin
                re         = 1'b1;
                raddr      = head_q;
                head_d     = ptr_add(head_q, CNT_W'(1));
                count_d    = count_q - CNT_W'(1);
                held_st_d  = STAT_RELEASED;
                held_cnt_d = count_q - CNT_W'(1);
                state_d    = ST_REL;
              end
            end
            REQ_TICK: begin
              src_d    = '0;
              dst_d    = '0;
              total_d  = count_q;
              pv_d     = 1'b0;
              held_v_d = 1'b0;
              state_d  = ST_TICK;
            end
            default: ;
          endcase
        end
      end

      ST_REL: begin
        held_id_d = rdata.tid;
        state_d   = ST_FLUSH;
      end

      ST_TICK: begin
        if (!stall) begin
          if (src_q != total_q) begin
            re    = 1'b1;
            raddr = ptr_add(head_q, src_q);
            src_d = src_q + CNT_W'(1);
            pv_d  = 1'b1;
          end else begin
            pv_d    = 1'b0;
            state_d = ST_FLUSH;
          end
          if (pv_q) begin
            if (expire) begin
              // previous expiry is not the last one: send it on
              push       = held_v_q;
              held_v_d   = 1'b1;
              held_st_d  = STAT_TIMEOUT;
              held_id_d  = rdata.tid;
              held_cnt_d = count_q - CNT_W'(1);
              count_d    = count_q - CNT_W'(1);
            end else begin
              we          = 1'b1;
              waddr       = ptr_add(head_q, dst_q);
              wdata.tid   = rdata.tid;
              wdata.ticks = (rdata.ticks == '0) ? '0 : rdata.ticks - WAIT_W'(1);
              dst_d       = dst_q + CNT_W'(1);
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!held_v_q) begin
            push_st  = STAT_NONE;
            push_id  = '0;
            push_cnt = count_q;
          end
          held_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d    = ov_q;
    ost_d   = ost_q;
    oid_d   = oid_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;
    if (push) begin
      ov_d    = 1'b1;
      ost_d   = push_st;
      oid_d   = push_id;
      ocnt_d  = push_cnt;
      olast_d = push_last;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      total_q  <= '0;
      pv_q     <= 1'b0;
      held_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      total_q  <= total_d;
      pv_q     <= pv_d;
      held_v_q <= held_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_st_q  <= held_st_d;
    held_id_q  <= held_id_d;
    held_cnt_q <= held_cnt_d;
    ost_q      <= ost_d;
    oid_q      <= oid_d;
    ocnt_q     <= ocnt_d;
    olast_q    <= olast_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = ost_q;
  assign out_o.released_id   = 8'(oid_q);
  assign out_o.blocked_count = 5'(ocnt_q);
  assign out_o.last_of_run   = olast_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> (dst_q <= src_q && src_q <= total_q))
    else $error("tick walk write index passed read index");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && $past(state_q) == ST_TICK) |-> (count_q == dst_q))
    else $error("count after tick differs from survivors");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result beat overwrote a pending beat");

endmodule
